[hw/rtl/motor_current_sense_calibrator_unit_macros.svh]
// Assertion macros for the motor current sense calibrator.
`ifndef MOTOR_CURRENT_SENSE_CALIBRATOR_UNIT_MACROS_SVH
`define MOTOR_CURRENT_SENSE_CALIBRATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define MCSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled in reset.
`define MCSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/mcsc_pkg.sv]
// Package with types, codes and constants of the motor current sense calibrator.
package mcsc_pkg;

  localparam int SAMPLE_W = 12;
  localparam int MAX_SAMPLES_DEF = 32;
  localparam int CUR_W = 14;
  localparam int DIV_W = 21;
  localparam int DIVR_W = 9;
  localparam int TICKS_W = 10;

  localparam logic [1:0] CMD_CUR = 2'd0;
  localparam logic [1:0] CMD_VOLT = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;
  localparam logic [1:0] CMD_RECAL = 2'd3;

  localparam logic [1:0] REG_UV_LIMIT = 2'd0;
  localparam logic [1:0] REG_OFFSET_TICKS = 2'd1;
  localparam logic [1:0] REG_SETTLE_TICKS = 2'd2;

  localparam logic [11:0] UV_LIMIT_RST = 12'd426;
  localparam logic [8:0] OFFSET_TICKS_RST = 9'd250;
  localparam logic [8:0] SETTLE_TICKS_RST = 9'd100;
  localparam logic [TICKS_W-1:0] CALIB_TICKS_RST =
    TICKS_W'(OFFSET_TICKS_RST) + TICKS_W'(SETTLE_TICKS_RST) + TICKS_W'(1);

  localparam logic signed [31:0] CUR_GAIN = 32'sd480;
  localparam logic signed [31:0] CUR_LIMIT = 32'sd7680;

  typedef struct packed {
    logic [1:0] cmd;
    logic [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [CUR_W-1:0] motor_current;
    logic supply_ok;
    logic calibrated;
    logic control_enable;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic [DIV_W-1:0] dividend;
    logic [DIVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

[hw/rtl/mcsc_div.sv]
// Restoring divider that produces one quotient bit per cycle.
module mcsc_div
  import mcsc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIV_W);

  logic [DIVR_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DIVR_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;
  logic [DIVR_W:0] trial;
  logic [DIVR_W:0] diff;
  logic fits;

  always_comb begin
    trial = {rem_r, quo_r[DIV_W-1]};
    diff = trial - {1'b0, dvs_r};
    fits = (trial >= {1'b0, dvs_r});
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt = '0;
      quo_nxt = req.dividend;
      dvs_nxt = req.divisor;
      cnt_nxt = CNT_W'(DIV_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], fits};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quotient = quo_r;

endmodule

[hw/rtl/mcsc_corr.sv]
// Offset correction: scales offset minus mean by 480, shifts by 8 and saturates.
module mcsc_corr
  import mcsc_pkg::*;
(
  input  logic                    clk,
  input  logic                    load,
  input  logic [DIV_W-1:0]        offset,
  input  logic [SAMPLE_W-1:0]     mean,
  output logic signed [CUR_W-1:0] current
);

  logic signed [DIV_W+1:0] diff;
  logic signed [31:0] prod_r, prod_nxt;
  logic signed [31:0] shifted;

  always_comb begin
    diff = $signed({2'b00, offset}) - $signed({{(DIV_W+2-SAMPLE_W){1'b0}}, mean});
    prod_nxt = $signed({{(32-DIV_W-2){diff[DIV_W+1]}}, diff}) * CUR_GAIN;
    shifted = prod_r >>> 8;
    priority if (shifted > CUR_LIMIT) begin
      current = CUR_W'(CUR_LIMIT);
    end else if (shifted < -CUR_LIMIT) begin
      current = CUR_W'(-CUR_LIMIT);
    end else begin
      current = shifted[CUR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

[hw/rtl/motor_current_sense_calibrator_unit.sv]
// Top level of the motor current sense calibrator with sequencer and state.
// Sample and recalibrate words leave the unit idle, ready for the next word, and give no result.
// A tick word takes both means on the shared divider, then passes CAL, MUL, SAT and
// OUT and frees the input in the cycle its result appears. An offset divide is added,
// an empty mean skips its divide, a summing-phase tick skips MUL and SAT, and a full
// output register stalls it. Synchronous active-low reset clears sums and flags.
module motor_current_sense_calibrator_unit
  import mcsc_pkg::*;
#(
  parameter int MAX_SAMPLES_PER_TICK = MAX_SAMPLES_DEF
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [11:0] cfg_wdata
);

  `include "motor_current_sense_calibrator_unit_macros.svh"

  localparam int CNT_W = $clog2(MAX_SAMPLES_PER_TICK + 1);
  localparam int SUM_W = $clog2(MAX_SAMPLES_PER_TICK * 4095 + 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_I_GO = 4'd1;
  localparam logic [3:0] ST_I_WAIT = 4'd2;
  localparam logic [3:0] ST_V_GO = 4'd3;
  localparam logic [3:0] ST_V_WAIT = 4'd4;
  localparam logic [3:0] ST_CAL = 4'd5;
  localparam logic [3:0] ST_O_GO = 4'd6;
  localparam logic [3:0] ST_O_WAIT = 4'd7;
  localparam logic [3:0] ST_MUL = 4'd8;
  localparam logic [3:0] ST_SAT = 4'd9;
  localparam logic [3:0] ST_OUT = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic [11:0] uv_limit_r;
  logic [8:0] offset_ticks_r, settle_ticks_r;
  logic [SUM_W-1:0] cur_sum_r, cur_sum_nxt, volt_sum_r, volt_sum_nxt;
  logic [CNT_W-1:0] cur_cnt_r, cur_cnt_nxt, volt_cnt_r, volt_cnt_nxt;
  logic [TICKS_W-1:0] calib_ticks_r, calib_ticks_nxt;
  logic [DIV_W-1:0] offset_accum_r, offset_accum_nxt;
  logic signed [CUR_W-1:0] current_hold_r, current_hold_nxt;
  logic calib_done_r, calib_done_nxt;
  logic [SAMPLE_W-1:0] mi_r, mi_nxt, mv_r, mv_nxt;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;
  logic [TICKS_W-1:0] end_ticks;
  logic [TICKS_W-1:0] offset_ticks_ext;
  logic accept;
  logic corr_load;
  logic signed [CUR_W-1:0] corr_current;
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic div_wait_st;
  logic cnt_ok;
  logic out_load;

  assign end_ticks = TICKS_W'(offset_ticks_r) + TICKS_W'(settle_ticks_r);
  assign offset_ticks_ext = TICKS_W'(offset_ticks_r);
  assign in_ready = (state_r == ST_IDLE);
  assign accept = in_valid && in_ready;
  assign corr_load = (state_r == ST_MUL);

  mcsc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  mcsc_corr u_corr (
    .clk     (clk),
    .load    (corr_load),
    .offset  (offset_accum_r),
    .mean    (mi_r),
    .current (corr_current)
  );

  always_comb begin
    state_nxt = state_r;
    cur_sum_nxt = cur_sum_r;
    cur_cnt_nxt = cur_cnt_r;
    volt_sum_nxt = volt_sum_r;
    volt_cnt_nxt = volt_cnt_r;
    calib_ticks_nxt = calib_ticks_r;
    offset_accum_nxt = offset_accum_r;
    current_hold_nxt = current_hold_r;
    calib_done_nxt = calib_done_r;
    mi_nxt = mi_r;
    mv_nxt = mv_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt = out_item_r;
    div_req.start = 1'b0;
    div_req.dividend = '0;
    div_req.divisor = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_item.cmd)
            CMD_CUR: begin
              if (cur_cnt_r < CNT_W'(MAX_SAMPLES_PER_TICK)) begin
                cur_sum_nxt = cur_sum_r + SUM_W'(in_item.sample);
                cur_cnt_nxt = cur_cnt_r + CNT_W'(1);
              end
            end
            CMD_VOLT: begin
              if (volt_cnt_r < CNT_W'(MAX_SAMPLES_PER_TICK)) begin
                volt_sum_nxt = volt_sum_r + SUM_W'(in_item.sample);
                volt_cnt_nxt = volt_cnt_r + CNT_W'(1);
              end
            end
            CMD_TICK: begin
              state_nxt = ST_I_GO;
            end
            CMD_RECAL: begin
              calib_ticks_nxt = '0;
              offset_accum_nxt = '0;
              calib_done_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_I_GO: begin
        cur_sum_nxt = '0;
        cur_cnt_nxt = '0;
        if (cur_cnt_r == '0) begin
          mi_nxt = '0;
          state_nxt = ST_V_GO;
        end else begin
          div_req.start = 1'b1;
          div_req.dividend = {{(DIV_W-SUM_W){1'b0}}, cur_sum_r};
          div_req.divisor = {{(DIVR_W-CNT_W){1'b0}}, cur_cnt_r};
          state_nxt = ST_I_WAIT;
        end
      end
      ST_I_WAIT: begin
        if (div_rsp.done) begin
          mi_nxt = div_rsp.quotient[SAMPLE_W-1:0];
          state_nxt = ST_V_GO;
        end
      end
      ST_V_GO: begin
        volt_sum_nxt = '0;
        volt_cnt_nxt = '0;
        if (volt_cnt_r == '0) begin
          mv_nxt = '0;
          state_nxt = ST_CAL;
        end else begin
          div_req.start = 1'b1;
          div_req.dividend = {{(DIV_W-SUM_W){1'b0}}, volt_sum_r};
          div_req.divisor = {{(DIVR_W-CNT_W){1'b0}}, volt_cnt_r};
          state_nxt = ST_V_WAIT;
        end
      end
      ST_V_WAIT: begin
        if (div_rsp.done) begin
          mv_nxt = div_rsp.quotient[SAMPLE_W-1:0];
          state_nxt = ST_CAL;
        end
      end
      ST_CAL: begin
        priority if (calib_ticks_r < offset_ticks_ext) begin
          calib_ticks_nxt = calib_ticks_r + TICKS_W'(1);
          offset_accum_nxt = offset_accum_r + DIV_W'(mi_r);
          state_nxt = ST_OUT;
        end else if (calib_ticks_r == offset_ticks_ext && offset_ticks_r != '0) begin
          state_nxt = ST_O_GO;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_O_GO: begin
        div_req.start = 1'b1;
        div_req.dividend = offset_accum_r;
        div_req.divisor = offset_ticks_r;
        state_nxt = ST_O_WAIT;
      end
      ST_O_WAIT: begin
        if (div_rsp.done) begin
          offset_accum_nxt = div_rsp.quotient;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_SAT;
      end
      ST_SAT: begin
        current_hold_nxt = corr_current;
        if (calib_ticks_r <= end_ticks) begin
          calib_ticks_nxt = calib_ticks_r + TICKS_W'(1);
          if (calib_ticks_r == end_ticks) begin
            calib_done_nxt = 1'b1;
          end
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_item_nxt.motor_current = current_hold_r;
          out_item_nxt.supply_ok = (mv_r > uv_limit_r);
          out_item_nxt.calibrated = calib_done_r;
          out_item_nxt.control_enable = (calib_ticks_r > end_ticks);
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      uv_limit_r <= UV_LIMIT_RST;
      offset_ticks_r <= OFFSET_TICKS_RST;
      settle_ticks_r <= SETTLE_TICKS_RST;
      cur_sum_r <= '0;
      cur_cnt_r <= '0;
      volt_sum_r <= '0;
      volt_cnt_r <= '0;
      calib_ticks_r <= CALIB_TICKS_RST;
      offset_accum_r <= '0;
      current_hold_r <= '0;
      calib_done_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cur_sum_r <= cur_sum_nxt;
      cur_cnt_r <= cur_cnt_nxt;
      volt_sum_r <= volt_sum_nxt;
      volt_cnt_r <= volt_cnt_nxt;
      calib_ticks_r <= calib_ticks_nxt;
      offset_accum_r <= offset_accum_nxt;
      current_hold_r <= current_hold_nxt;
      calib_done_r <= calib_done_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_UV_LIMIT: uv_limit_r <= cfg_wdata;
          REG_OFFSET_TICKS: offset_ticks_r <= cfg_wdata[8:0];
          REG_SETTLE_TICKS: settle_ticks_r <= cfg_wdata[8:0];
          default: begin
          end
        endcase
      end
    end
    mi_r <= mi_nxt;
    mv_r <= mv_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item = out_item_r;

  assign div_wait_st = (state_r == ST_I_WAIT) || (state_r == ST_V_WAIT) ||
                       (state_r == ST_O_WAIT);
  assign cnt_ok = (cur_cnt_r <= CNT_W'(MAX_SAMPLES_PER_TICK)) &&
                  (volt_cnt_r <= CNT_W'(MAX_SAMPLES_PER_TICK));
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  `MCSC_ASSERT_NOW(a_div_busy_waits, div_rsp.busy, div_wait_st, "divider busy outside a wait")
  `MCSC_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_ok, "sample count above limit")
  `MCSC_ASSERT_NEXT(a_out_load, out_load, (out_valid_r && state_r == ST_IDLE), "result not loaded")

endmodule

[dv/tb_motor_current_sense_calibrator_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench that drives ADC words, ticks and recalibration into the calibrator.
module tb_motor_current_sense_calibrator_unit;
  import mcsc_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int TARGET_WORDS = 1850;
  localparam int MAX_PRINTS = 50;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_item;
  logic out_valid;
  logic out_ready;
  out_item_t out_item;
  logic cfg_we;
  logic [1:0] cfg_idx;
  logic [11:0] cfg_wdata;

  logic [11:0] uv_limit_q;
  logic [8:0] offset_ticks_q;
  logic [8:0] settle_ticks_q;
  logic [16:0] cur_sum;
  logic [5:0] cur_cnt;
  logic [16:0] volt_sum;
  logic [5:0] volt_cnt;
  logic [9:0] calib_ticks;
  logic [20:0] offset_acc;
  logic signed [13:0] current_hold;
  logic calib_done;

  out_item_t pending_readings[$];
  int err_count = 0;
  int words_sent = 0;
  int cycle_count = 0;
  bit no_idle = 1'b0;
  bit hold_off_req = 1'b0;

  always #5 clk = ~clk;

  motor_current_sense_calibrator_unit u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  task automatic report_mismatch(string field, int got, int want);
    if (err_count < MAX_PRINTS) begin
      $display("mismatch in %s: got %0d, expected %0d (cycle %0d)", field, got, want,
               cycle_count);
    end
    err_count++;
  endtask

  function automatic logic signed [13:0] offset_corrected(logic [11:0] mean);
    longint diff;
    longint prod;
    longint q;
    diff = longint'(offset_acc) - longint'(mean);
    prod = diff * longint'(CUR_GAIN);
    q = prod >>> 8;
    if (q > longint'(CUR_LIMIT)) q = longint'(CUR_LIMIT);
    if (q < -longint'(CUR_LIMIT)) q = -longint'(CUR_LIMIT);
    return q[13:0];
  endfunction

  task automatic reset_prediction();
    uv_limit_q = UV_LIMIT_RST;
    offset_ticks_q = OFFSET_TICKS_RST;
    settle_ticks_q = SETTLE_TICKS_RST;
    cur_sum = '0;
    cur_cnt = '0;
    volt_sum = '0;
    volt_cnt = '0;
    calib_ticks = CALIB_TICKS_RST;
    offset_acc = '0;
    current_hold = '0;
    calib_done = 1'b0;
  endtask

  task automatic predict_word(in_item_t w);
    logic [11:0] mean_cur;
    logic [11:0] mean_volt;
    logic [10:0] end_tick;
    out_item_t r;
    end_tick = 11'(offset_ticks_q) + 11'(settle_ticks_q);
    case (w.cmd)
      CMD_CUR: begin
        if (cur_cnt < MAX_SAMPLES_DEF) begin
          cur_sum = cur_sum + w.sample;
          cur_cnt = cur_cnt + 1'b1;
        end
      end
      CMD_VOLT: begin
        if (volt_cnt < MAX_SAMPLES_DEF) begin
          volt_sum = volt_sum + w.sample;
          volt_cnt = volt_cnt + 1'b1;
        end
      end
      CMD_RECAL: begin
        calib_ticks = '0;
        offset_acc = '0;
        calib_done = 1'b0;
      end
      default: begin
        mean_cur = (cur_cnt != 0) ? 12'(cur_sum / cur_cnt) : 12'd0;
        mean_volt = (volt_cnt != 0) ? 12'(volt_sum / volt_cnt) : 12'd0;
        cur_sum = '0;
        cur_cnt = '0;
        volt_sum = '0;
        volt_cnt = '0;
        if (calib_ticks < offset_ticks_q) begin
          calib_ticks = calib_ticks + 1'b1;
          offset_acc = offset_acc + mean_cur;
        end else begin
          if (calib_ticks == offset_ticks_q && offset_ticks_q != 0) begin
            offset_acc = offset_acc / offset_ticks_q;
          end
          current_hold = offset_corrected(mean_cur);
          if (calib_ticks <= end_tick) begin
            calib_ticks = calib_ticks + 1'b1;
            if (calib_ticks == end_tick + 1) calib_done = 1'b1;
          end
        end
        r.motor_current = current_hold;
        r.supply_ok = (mean_volt > uv_limit_q);
        r.calibrated = calib_done;
        r.control_enable = (calib_ticks > end_tick);
        pending_readings.push_back(r);
      end
    endcase
  endtask

  task automatic send_word(logic [1:0] cmd, logic [11:0] sample);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item = {cmd, sample};
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_word(in_item);
    words_sent++;
  endtask

  task automatic settle_block();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [11:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_UV_LIMIT: uv_limit_q = data;
      REG_OFFSET_TICKS: offset_ticks_q = data[8:0];
      REG_SETTLE_TICKS: settle_ticks_q = data[8:0];
      default: ;
    endcase
  endtask

  function automatic logic [11:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 12'd0;
      1: return 12'd4095;
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic logic [8:0] pick_offset_ticks();
    case ($urandom_range(0, 9))
      0: return 9'd0;
      1: return 9'd511;
      2: return 9'($urandom_range(100, 511));
      default: return 9'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [8:0] pick_settle_ticks();
    case ($urandom_range(0, 9))
      0: return 9'd0;
      1: return 9'd511;
      default: return 9'($urandom_range(0, 6));
    endcase
  endfunction

  task automatic send_frame();
    int n_cur;
    int n_volt;
    n_cur = $urandom_range(0, 6);
    n_volt = $urandom_range(0, 6);
    if ($urandom_range(0, 19) == 0) n_cur = $urandom_range(28, 40);
    if ($urandom_range(0, 19) == 0) n_volt = $urandom_range(28, 40);
    while (n_cur + n_volt > 0) begin
      if ($urandom_range(0, 9) == 0) send_word(2'($urandom), 12'($urandom));
      if (n_cur > 0 && (n_volt == 0 || $urandom_range(0, 1) == 1)) begin
        send_word(CMD_CUR, pick_sample());
        n_cur--;
      end else begin
        send_word(CMD_VOLT, pick_sample());
        n_volt--;
      end
    end
    if ($urandom_range(0, 11) == 0) send_word(CMD_RECAL, 12'($urandom));
    send_word(CMD_TICK, 12'($urandom));
  endtask

  task automatic test_power_on();
    send_word(CMD_TICK, 12'd0);
    send_word(CMD_CUR, 12'd0);
    send_word(CMD_VOLT, 12'd4095);
    send_word(CMD_TICK, 12'hABC);
    settle_block();
  endtask

  task automatic test_zero_settle_run();
    write_reg(REG_OFFSET_TICKS, 12'd1);
    write_reg(REG_SETTLE_TICKS, 12'd0);
    write_reg(REG_UV_LIMIT, 12'd0);
    send_word(CMD_CUR, 12'd4095);
    send_word(CMD_RECAL, 12'hFFF);
    send_word(CMD_VOLT, 12'd1);
    send_word(CMD_TICK, 12'd0);
    send_word(CMD_CUR, 12'd0);
    send_word(CMD_VOLT, 12'd0);
    send_word(CMD_TICK, 12'd0);
    send_word(CMD_CUR, 12'd4095);
    send_word(CMD_TICK, 12'd0);
    settle_block();
  endtask

  task automatic test_summing_hold();
    write_reg(REG_OFFSET_TICKS, 12'd2);
    write_reg(REG_SETTLE_TICKS, 12'd2);
    write_reg(REG_UV_LIMIT, 12'd4095);
    send_word(CMD_RECAL, 12'd0);
    send_word(CMD_CUR, 12'd100);
    send_word(CMD_TICK, 12'd0);
    send_word(CMD_CUR, 12'd200);
    send_word(CMD_VOLT, 12'd4095);
    send_word(CMD_TICK, 12'd0);
    repeat (4) send_word(CMD_TICK, 12'd0);
    settle_block();
  endtask

  task automatic test_skipped_divide();
    write_reg(REG_SETTLE_TICKS, 12'd1);
    send_word(CMD_RECAL, 12'd0);
    send_word(CMD_CUR, 12'd4095);
    send_word(CMD_TICK, 12'd0);
    send_word(CMD_CUR, 12'd4095);
    send_word(CMD_TICK, 12'd0);
    settle_block();
    write_reg(REG_OFFSET_TICKS, 12'd1);
    send_word(CMD_TICK, 12'd0);
    settle_block();
  endtask

  task automatic test_zero_offset();
    write_reg(REG_OFFSET_TICKS, 12'd0);
    write_reg(REG_SETTLE_TICKS, 12'd1);
    send_word(CMD_RECAL, 12'd0);
    send_word(CMD_CUR, 12'd10);
    repeat (3) send_word(CMD_TICK, 12'd0);
    settle_block();
  endtask

  task automatic test_sample_overflow();
    write_reg(REG_OFFSET_TICKS, 12'd1);
    write_reg(REG_SETTLE_TICKS, 12'd0);
    write_reg(REG_UV_LIMIT, 12'd1000);
    send_word(CMD_RECAL, 12'd0);
    send_word(CMD_TICK, 12'd0);
    repeat (32) send_word(CMD_CUR, 12'd1000);
    repeat (6) send_word(CMD_CUR, 12'd4095);
    repeat (32) send_word(CMD_VOLT, 12'd1001);
    repeat (5) send_word(CMD_VOLT, 12'd0);
    send_word(CMD_TICK, 12'd0);
    settle_block();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_OFFSET_TICKS, 12'hFFF);
    write_reg(REG_SETTLE_TICKS, 12'hFFF);
    write_reg(REG_UV_LIMIT, 12'd4095);
    send_word(CMD_RECAL, 12'd0);
    repeat (5) send_frame();
    settle_block();
    write_reg(REG_UNUSED, 12'($urandom));
    write_reg(REG_OFFSET_TICKS, 12'h001);
    send_word(CMD_TICK, 12'd0);
    settle_block();
  endtask

  task automatic test_output_stall();
    write_reg(REG_OFFSET_TICKS, 12'd2);
    write_reg(REG_SETTLE_TICKS, 12'd3);
    send_word(CMD_RECAL, 12'd0);
    hold_off_req = 1'b1;
    repeat (12) send_frame();
    settle_block();
  endtask

  task automatic test_random();
    int n_frames;
    while (words_sent < TARGET_WORDS) begin
      settle_block();
      no_idle = ($urandom_range(0, 3) == 0);
      write_reg(REG_UV_LIMIT, pick_sample());
      write_reg(REG_OFFSET_TICKS, {3'($urandom), pick_offset_ticks()});
      write_reg(REG_SETTLE_TICKS, {3'($urandom), pick_settle_ticks()});
      if ($urandom_range(0, 3) != 0) send_word(CMD_RECAL, 12'($urandom));
      n_frames = $urandom_range(8, 30);
      repeat (n_frames) send_frame();
    end
    no_idle = 1'b0;
  endtask

  initial begin : drive_out_ready
    int gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : check_readings
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("word with nothing pending", out_item.motor_current, 0);
      end else begin
        want = pending_readings.pop_front();
        if (out_item.motor_current !== want.motor_current)
          report_mismatch("motor_current", out_item.motor_current, want.motor_current);
        if (out_item.supply_ok !== want.supply_ok)
          report_mismatch("supply_ok", out_item.supply_ok, want.supply_ok);
        if (out_item.calibrated !== want.calibrated)
          report_mismatch("calibrated", out_item.calibrated, want.calibrated);
        if (out_item.control_enable !== want.control_enable)
          report_mismatch("control_enable", out_item.control_enable, want.control_enable);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("motor_current_sense_calibrator_unit verification failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_idx = REG_UV_LIMIT;
    cfg_wdata = '0;
    reset_prediction();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_power_on();
    test_zero_settle_run();
    test_summing_hold();
    test_skipped_divide();
    test_zero_offset();
    test_sample_overflow();
    test_register_extremes();
    test_output_stall();
    test_random();
    settle_block();
    if (err_count == 0) begin
      $display("motor_current_sense_calibrator_unit verification clean");
    end else begin
      $display("motor_current_sense_calibrator_unit verification failed");
    end
    $finish;
  end

endmodule
